@@ rtl/two_class_priority_queue_macros.svh @@
// Assertion macros shared by the two-class priority queue RTL.
`ifndef TWO_CLASS_PRIORITY_QUEUE_MACROS_SVH
`define TWO_CLASS_PRIORITY_QUEUE_MACROS_SVH

// Same-cycle implication, checked outside reset.
`define CTPQ_ASSERT_NOW(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

// Next-cycle implication, checked outside reset.
`define CTPQ_ASSERT_NEXT(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

@@ rtl/ctpq_pkg.sv @@
// Shared types and constants of the two-class priority queue.
package ctpq_pkg;

	localparam int QUEUE_DEPTH = 16;
	localparam int ID_BITS     = 16;
	localparam int PTR_W       = $clog2(QUEUE_DEPTH);
	localparam int CNT_W       = $clog2(QUEUE_DEPTH + 1);

	localparam int AGE_W       = 8;
	localparam int TAG_W       = 32;
	localparam int OUT_ID_W    = 16;
	localparam int CFG_INDEX_W = 8;
	localparam int CFG_DATA_W  = 8;

	localparam int IN_TDATA_W  = 40;
	localparam int OUT_TDATA_W = 64;
	localparam int OUT_PAD_W   = OUT_TDATA_W - (OUT_ID_W + AGE_W + TAG_W + 1);

	localparam logic [AGE_W-1:0]   CHILD_AGE_RESET  = AGE_W'(12);
	localparam logic [AGE_W-1:0]   SENIOR_AGE_RESET = AGE_W'(60);
	localparam logic [ID_BITS-1:0] SEQ_RESET        = ID_BITS'(1);

	// Configuration register indexes
	localparam logic [CFG_INDEX_W-1:0] CFG_CHILD_AGE_MAX  = CFG_INDEX_W'(0);
	localparam logic [CFG_INDEX_W-1:0] CFG_SENIOR_AGE_MIN = CFG_INDEX_W'(1);

	typedef enum logic {
		CMD_REGISTER = 1'b0,
		CMD_SERVE    = 1'b1
	} cmd_t;

	typedef enum logic [1:0] {
		STAT_REGISTERED = 2'd0,
		STAT_REJECTED   = 2'd1,
		STAT_SERVED     = 2'd2,
		STAT_EMPTY      = 2'd3
	} status_t;

	typedef enum logic {
		ST_IDLE = 1'b0,
		ST_READ = 1'b1
	} state_t;

	// One stored entry
	typedef struct packed {
		logic [ID_BITS-1:0] id;
		logic [AGE_W-1:0]   age;
		logic [TAG_W-1:0]   tag;
	} slot_t;

	// Controller to datapath
	typedef struct packed {
		logic take_reg;
		logic pop_prio;
		logic pop_norm;
		logic load_none;
		logic load_read;
	} ctrl_cmd_t;

	// Datapath to controller
	typedef struct packed {
		logic prio_empty;
		logic norm_empty;
		logic out_free;
	} dp_status_t;

endpackage

@@ rtl/ctpq_fifo.sv @@
// Bounded FIFO with registered read port, used for each priority class.
module ctpq_fifo (
	input  logic           clk,
	input  logic           arst_n,
	input  logic           push,
	input  ctpq_pkg::slot_t push_data,
	input  logic           pop,
	output ctpq_pkg::slot_t rd_data,
	output logic           empty,
	output logic           full
);
	import ctpq_pkg::*;

	slot_t            mem [QUEUE_DEPTH];
	slot_t            rd_data_q;
	logic [PTR_W-1:0] head_q;
	logic [PTR_W-1:0] tail_q;
	logic [CNT_W-1:0] count_q;

	function automatic logic [PTR_W-1:0] ptr_next(input logic [PTR_W-1:0] p);
		if (p == PTR_W'(QUEUE_DEPTH - 1)) begin
			return '0;
		end
		return p + PTR_W'(1);
	endfunction

	assign empty   = (count_q == '0);
	assign full    = (count_q == CNT_W'(QUEUE_DEPTH));
	assign rd_data = rd_data_q;

	// Storage: write at tail, registered read at head
	always_ff @(posedge clk) begin
		if (push) begin
			mem[tail_q] <= push_data;
		end
		if (pop) begin
			rd_data_q <= mem[head_q];
		end
	end

	// Pointers and fill count
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			head_q  <= '0;
			tail_q  <= '0;
			count_q <= '0;
		end else begin
			if (push) begin
				tail_q <= ptr_next(tail_q);
			end
			if (pop) begin
				head_q <= ptr_next(head_q);
			end
			if (push && !pop) begin
				count_q <= count_q + CNT_W'(1);
			end else if (pop && !push) begin
				count_q <= count_q - CNT_W'(1);
			end
		end
	end

`include "two_class_priority_queue_macros.svh"

	`CTPQ_ASSERT_NOW(a_no_push_full, push, !full || pop, "push into full FIFO")
	`CTPQ_ASSERT_NOW(a_no_pop_empty, pop, !empty, "pop from empty FIFO")
	`CTPQ_ASSERT_NEXT(a_count_up, push && !pop, count_q == $past(count_q) + CNT_W'(1), "count did not follow push")

endmodule

@@ rtl/ctpq_datapath.sv @@
// Datapath: config registers, classification, sequence counter, FIFOs, result register.
module ctpq_datapath (
	input  logic                                       clk,
	input  logic                                       arst_n,
	input  logic                                       cfg_we,
	input  logic [ctpq_pkg::CFG_INDEX_W-1:0]           cfg_index,
	input  logic [ctpq_pkg::CFG_DATA_W-1:0]            cfg_data,
	input  logic [ctpq_pkg::IN_TDATA_W-1:0]            in_data,
	input  ctpq_pkg::ctrl_cmd_t                        cmd,
	output ctpq_pkg::dp_status_t                       stat,
	input  logic                                       out_ready,
	output logic                                       out_valid,
	output logic [ctpq_pkg::OUT_TDATA_W-1:0]           out_data,
	output ctpq_pkg::status_t                          out_status
);
	import ctpq_pkg::*;

	logic [AGE_W-1:0]    child_q;
	logic [AGE_W-1:0]    senior_q;
	logic [ID_BITS-1:0]  seq_q;
	logic                sel_prio_q;

	logic                out_valid_q;
	status_t             status_q;
	logic [OUT_ID_W-1:0] id_q;
	logic [AGE_W-1:0]    age_q;
	logic [TAG_W-1:0]    tag_q;
	logic                prio_q;

	logic [AGE_W-1:0]    in_age;
	logic [TAG_W-1:0]    in_tag;
	logic                hi;
	logic                tgt_full;
	logic                push_prio;
	logic                push_norm;
	slot_t               new_slot;
	slot_t               prio_rd;
	slot_t               norm_rd;
	slot_t               rd_slot;
	logic                prio_empty;
	logic                prio_full;
	logic                norm_empty;
	logic                norm_full;

	assign in_age = in_data[AGE_W-1:0];
	assign in_tag = in_data[AGE_W +: TAG_W];

	// Classification and push decision
	assign hi        = (in_age <= child_q) || (in_age >= senior_q);
	assign tgt_full  = hi ? prio_full : norm_full;
	assign push_prio = cmd.take_reg && hi && !prio_full;
	assign push_norm = cmd.take_reg && !hi && !norm_full;
	assign new_slot  = '{id: seq_q, age: in_age, tag: in_tag};
	assign rd_slot   = sel_prio_q ? prio_rd : norm_rd;

	ctpq_fifo u_prio_fifo (
		.clk      (clk),
		.arst_n   (arst_n),
		.push     (push_prio),
		.push_data(new_slot),
		.pop      (cmd.pop_prio),
		.rd_data  (prio_rd),
		.empty    (prio_empty),
		.full     (prio_full)
	);

	ctpq_fifo u_norm_fifo (
		.clk      (clk),
		.arst_n   (arst_n),
		.push     (push_norm),
		.push_data(new_slot),
		.pop      (cmd.pop_norm),
		.rd_data  (norm_rd),
		.empty    (norm_empty),
		.full     (norm_full)
	);

	// Config registers and sequence counter
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			child_q  <= CHILD_AGE_RESET;
			senior_q <= SENIOR_AGE_RESET;
			seq_q    <= SEQ_RESET;
		end else begin
			if (cfg_we && cfg_index == CFG_CHILD_AGE_MAX) begin
				child_q <= cfg_data;
			end
			if (cfg_we && cfg_index == CFG_SENIOR_AGE_MIN) begin
				senior_q <= cfg_data;
			end
			if (push_prio || push_norm) begin
				seq_q <= seq_q + ID_BITS'(1);
			end
		end
	end

	// Remember which FIFO the pending read came from
	always_ff @(posedge clk) begin
		if (cmd.pop_prio || cmd.pop_norm) begin
			sel_prio_q <= cmd.pop_prio;
		end
	end

	// Result register valid
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (cmd.take_reg || cmd.load_none || cmd.load_read) begin
			out_valid_q <= 1'b1;
		end else if (out_ready) begin
			out_valid_q <= 1'b0;
		end
	end

	// Result register payload
	always_ff @(posedge clk) begin
		if (cmd.take_reg) begin
			status_q <= tgt_full ? STAT_REJECTED : STAT_REGISTERED;
			id_q     <= tgt_full ? '0 : OUT_ID_W'(seq_q);
			age_q    <= '0;
			tag_q    <= '0;
			prio_q   <= hi && !tgt_full;
		end else if (cmd.load_none) begin
			status_q <= STAT_EMPTY;
			id_q     <= '0;
			age_q    <= '0;
			tag_q    <= '0;
			prio_q   <= 1'b0;
		end else if (cmd.load_read) begin
			status_q <= STAT_SERVED;
			id_q     <= OUT_ID_W'(rd_slot.id);
			age_q    <= rd_slot.age;
			tag_q    <= rd_slot.tag;
			prio_q   <= sel_prio_q;
		end
	end

	assign stat.prio_empty = prio_empty;
	assign stat.norm_empty = norm_empty;
	assign stat.out_free   = !out_valid_q || out_ready;

	assign out_valid  = out_valid_q;
	assign out_status = status_q;
	assign out_data   = {{OUT_PAD_W{1'b0}}, prio_q, tag_q, age_q, id_q};

endmodule

@@ rtl/ctpq_ctrl.sv @@
// Controller state machine: accepts requests and sequences FIFO reads.
module ctpq_ctrl (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 in_valid,
	input  ctpq_pkg::cmd_t       in_cmd,
	output logic                 in_ready,
	input  ctpq_pkg::dp_status_t stat,
	output ctpq_pkg::ctrl_cmd_t  cmd
);
	import ctpq_pkg::*;

	state_t state_q;
	state_t state_d;
	logic   accept;

	assign accept = in_valid && in_ready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	// Next state
	always_comb begin
		state_d = state_q;
		case (state_q)
			ST_IDLE: begin
				if (accept && in_cmd == CMD_SERVE &&
				    !(stat.prio_empty && stat.norm_empty)) begin
					state_d = ST_READ;
				end
			end
			ST_READ: begin
				if (stat.out_free) begin
					state_d = ST_IDLE;
				end
			end
			default: state_d = ST_IDLE;
		endcase
	end

	// Outputs
	always_comb begin
		in_ready = 1'b0;
		cmd      = '0;
		case (state_q)
			ST_IDLE: begin
				in_ready = stat.out_free;
				if (accept) begin
					if (in_cmd == CMD_REGISTER) begin
						cmd.take_reg = 1'b1;
					end else if (!stat.prio_empty) begin
						cmd.pop_prio = 1'b1;
					end else if (!stat.norm_empty) begin
						cmd.pop_norm = 1'b1;
					end else begin
						cmd.load_none = 1'b1;
					end
				end
			end
			ST_READ: begin
				cmd.load_read = stat.out_free;
			end
			default: begin
				in_ready = 1'b0;
			end
		endcase
	end

`include "two_class_priority_queue_macros.svh"

	`CTPQ_ASSERT_NOW(a_one_cmd, 1'b1, $onehot0(cmd), "more than one datapath command")
	`CTPQ_ASSERT_NEXT(a_pop_then_read, cmd.pop_prio || cmd.pop_norm, state_q == ST_READ, "pop not followed by read state")

endmodule

@@ rtl/two_class_priority_queue.sv @@
// Top level of the two-class strict-priority queue.
//
//  Channel   Dir  Handshake                     Payload
//  s_axis    in   s_axis_tvalid/s_axis_tready   tuser=cmd, tdata=age,name_tag
//  m_axis    out  m_axis_tvalid/m_axis_tready   tuser=status, tdata=id,age,tag,prio
//  cfg       in   cfg_valid/cfg_ready           cfg_index, cfg_data
//
// A register request or an empty serve loads the result register directly; a serve
// that pops first reads through the registered read port of the FIFO storage.
// The input is ready when the result register is empty or its result is taken in
// the same cycle, except while a serve read is pending. A stalled output holds the
// result and blocks new work.
// Reset clears pointers and counts, loads the config reset values, and sets the next id
// to 1; FIFO storage is not cleared.
module two_class_priority_queue (
	input  logic                                  clk,
	input  logic                                  arst_n,
	input  logic                                  s_axis_tvalid,
	output logic                                  s_axis_tready,
	input  logic [ctpq_pkg::IN_TDATA_W-1:0]       s_axis_tdata,  // age[7:0], name_tag[39:8]
	input  logic                                  s_axis_tuser,  // cmd[0]
	output logic                                  m_axis_tvalid,
	input  logic                                  m_axis_tready,
	// entry_id[15:0], entry_age[23:16], entry_tag[55:24], from_priority[56], zero pad
	output logic [ctpq_pkg::OUT_TDATA_W-1:0]      m_axis_tdata,
	output logic [1:0]                            m_axis_tuser,  // status[1:0]
	input  logic                                  cfg_valid,
	output logic                                  cfg_ready,
	input  logic [ctpq_pkg::CFG_INDEX_W-1:0]      cfg_index,
	input  logic [ctpq_pkg::CFG_DATA_W-1:0]       cfg_data
);
	import ctpq_pkg::*;

	ctrl_cmd_t  cmd;
	dp_status_t stat;
	status_t    out_status;
	cmd_t       in_cmd;

	assign cfg_ready    = 1'b1;
	assign in_cmd       = cmd_t'(s_axis_tuser);
	assign m_axis_tuser = out_status;

	ctpq_ctrl u_ctrl (
		.clk     (clk),
		.arst_n  (arst_n),
		.in_valid(s_axis_tvalid),
		.in_cmd  (in_cmd),
		.in_ready(s_axis_tready),
		.stat    (stat),
		.cmd     (cmd)
	);

	ctpq_datapath u_dp (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_we    (cfg_valid && cfg_ready),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data),
		.in_data   (s_axis_tdata),
		.cmd       (cmd),
		.stat      (stat),
		.out_ready (m_axis_tready),
		.out_valid (m_axis_tvalid),
		.out_data  (m_axis_tdata),
		.out_status(out_status)
	);

endmodule

@@ sim/tb.sv @@
// Self-checking testbench for the two-class strict-priority queue.
module tb;
	timeunit 1ns;
	timeprecision 1ps;

	import ctpq_pkg::*;

	// One stored entry as the predictor sees it
	typedef struct packed {
		logic [15:0] id;
		logic [7:0]  age;
		logic [31:0] tag;
	} held_entry_t;

	// One result transfer
	typedef struct packed {
		status_t     status;
		logic [15:0] id;
		logic [7:0]  age;
		logic [31:0] tag;
		logic        prio;
	} outcome_t;

	localparam int ITEM_TARGET = 1950;
	localparam int TAIL_PAIRS  = 60;
	localparam int PRINT_CAP   = 40;

	logic                   clk;
	logic                   arst_n;
	logic                   s_axis_tvalid;
	logic                   s_axis_tready;
	logic [IN_TDATA_W-1:0]  s_axis_tdata;   // age[7:0], name_tag[39:8]
	logic                   s_axis_tuser;   // cmd[0]
	logic                   m_axis_tvalid;
	logic                   m_axis_tready;
	logic [OUT_TDATA_W-1:0] m_axis_tdata;   // entry_id, entry_age, entry_tag, from_priority, pad
	logic [1:0]             m_axis_tuser;   // status[1:0]
	logic                   cfg_valid;
	logic                   cfg_ready;
	logic [CFG_INDEX_W-1:0] cfg_index;
	logic [CFG_DATA_W-1:0]  cfg_data;

	// Predictor state
	held_entry_t prio_line[$];
	held_entry_t norm_line[$];
	logic [15:0] next_id    = SEQ_RESET;
	logic [7:0]  child_lim  = CHILD_AGE_RESET;
	logic [7:0]  senior_lim = SENIOR_AGE_RESET;
	outcome_t    results_due[$];

	// Run control and statistics
	bit tx_idle;
	bit rx_idle;
	int hold_off;
	int stall_left;
	int items_sent;
	int fail_count;
	int stall_cycles;
	int status_seen[4];

	two_class_priority_queue DUT (
		.clk           (clk),
		.arst_n        (arst_n),
		.s_axis_tvalid (s_axis_tvalid),
		.s_axis_tready (s_axis_tready),
		.s_axis_tdata  (s_axis_tdata),
		.s_axis_tuser  (s_axis_tuser),
		.m_axis_tvalid (m_axis_tvalid),
		.m_axis_tready (m_axis_tready),
		.m_axis_tdata  (m_axis_tdata),
		.m_axis_tuser  (m_axis_tuser),
		.cfg_valid     (cfg_valid),
		.cfg_ready     (cfg_ready),
		.cfg_index     (cfg_index),
		.cfg_data      (cfg_data)
	);

	// Clock
	initial begin
		clk = 1'b0;
		forever #5 clk = ~clk;
	end

	// Watchdog
	initial begin
		#10_000_000;
		$display("two_class_priority_queue regression: fail");
		$finish;
	end

	// Mismatch reporting
	task automatic note_mismatch(input string what, input logic [63:0] got,
			input logic [63:0] want);
		fail_count++;
		if (fail_count <= PRINT_CAP) begin
			$display("[%0t] mismatch %s: got %0h expected %0h", $time, what, got, want);
		end
	endtask

	// Predict the result of one accepted request
	function automatic outcome_t schedule_request(cmd_t cmd, logic [7:0] age,
			logic [31:0] tag);
		outcome_t    r;
		held_entry_t e;
		logic        urgent;
		int          depth;
		r = '0;
		if (cmd == CMD_REGISTER) begin
			urgent = (age <= child_lim) || (age >= senior_lim);
			depth = urgent ? prio_line.size() : norm_line.size();
			if (depth >= QUEUE_DEPTH) begin
				r.status = STAT_REJECTED;
			end else begin
				e.id  = next_id;
				e.age = age;
				e.tag = tag;
				if (urgent) prio_line.push_back(e);
				else norm_line.push_back(e);
				next_id  = next_id + 16'd1;
				r.status = STAT_REGISTERED;
				r.id     = e.id;
				r.prio   = urgent;
			end
		end else if (prio_line.size() != 0) begin
			e = prio_line.pop_front();
			r.status = STAT_SERVED;
			r.id     = e.id;
			r.age    = e.age;
			r.tag    = e.tag;
			r.prio   = 1'b1;
		end else if (norm_line.size() != 0) begin
			e = norm_line.pop_front();
			r.status = STAT_SERVED;
			r.id     = e.id;
			r.age    = e.age;
			r.tag    = e.tag;
		end else begin
			r.status = STAT_EMPTY;
		end
		return r;
	endfunction

	// Monitor: check results, track register writes, predict accepted requests
	always @(posedge clk) begin : monitor
		outcome_t want;
		logic [1:0] got_status;
		if (arst_n) begin
			if (m_axis_tvalid && m_axis_tready) begin
				got_status = m_axis_tuser;
				status_seen[got_status]++;
				if (results_due.size() == 0) begin
					note_mismatch("result with nothing pending", m_axis_tdata, 64'd0);
				end else begin
					want = results_due.pop_front();
					if (got_status !== want.status)
						note_mismatch("status", 64'(got_status), 64'(want.status));
					if (m_axis_tdata[15:0] !== want.id)
						note_mismatch("entry_id", 64'(m_axis_tdata[15:0]), 64'(want.id));
					if (m_axis_tdata[23:16] !== want.age)
						note_mismatch("entry_age", 64'(m_axis_tdata[23:16]),
							64'(want.age));
					if (m_axis_tdata[55:24] !== want.tag)
						note_mismatch("entry_tag", 64'(m_axis_tdata[55:24]),
							64'(want.tag));
					if (m_axis_tdata[56] !== want.prio)
						note_mismatch("from_priority", 64'(m_axis_tdata[56]),
							64'(want.prio));
					if (m_axis_tdata[63:57] !== '0)
						note_mismatch("tdata pad", 64'(m_axis_tdata[63:57]), 64'd0);
				end
			end
			if (cfg_valid && cfg_ready) begin
				case (cfg_index)
					CFG_CHILD_AGE_MAX:  child_lim = cfg_data;
					CFG_SENIOR_AGE_MIN: senior_lim = cfg_data;
					default: ;
				endcase
			end
			if (s_axis_tvalid && s_axis_tready) begin
				results_due.push_back(schedule_request(cmd_t'(s_axis_tuser),
					s_axis_tdata[7:0], s_axis_tdata[39:8]));
			end
			if (s_axis_tvalid && !s_axis_tready) stall_cycles++;
		end
	end

	// Receiver: random stall bursts plus an optional long hold-off
	initial begin
		forever begin
			@(negedge clk);
			if (hold_off > 0) begin
				m_axis_tready <= 1'b0;
				hold_off--;
			end else if (stall_left > 0) begin
				m_axis_tready <= 1'b0;
				stall_left--;
			end else if (rx_idle && $urandom_range(0, 4) == 0) begin
				m_axis_tready <= 1'b0;
				stall_left = $urandom_range(0, 5);
			end else begin
				m_axis_tready <= 1'b1;
			end
		end
	end

	// Offer one request and wait for its transfer
	task automatic send_item(input cmd_t cmd, input logic [7:0] age, input logic [31:0] tag);
		@(negedge clk);
		if (tx_idle && $urandom_range(0, 3) == 0) begin
			s_axis_tvalid <= 1'b0;
			repeat ($urandom_range(1, 6)) @(negedge clk);
		end
		s_axis_tvalid <= 1'b1;
		s_axis_tuser  <= cmd;
		s_axis_tdata  <= {tag, age};
		do @(posedge clk); while (!s_axis_tready);
		items_sent++;
	endtask

	// Stop offering and wait until every result has come back
	task automatic wait_drained();
		@(negedge clk);
		s_axis_tvalid <= 1'b0;
		while (results_due.size() != 0) @(posedge clk);
	endtask

	// Register write, only while the block is idle
	task automatic write_reg(input logic [CFG_INDEX_W-1:0] idx, input logic [7:0] val);
		@(negedge clk);
		cfg_valid <= 1'b1;
		cfg_index <= idx;
		cfg_data  <= val;
		do @(posedge clk); while (!cfg_ready);
		@(negedge clk);
		cfg_valid <= 1'b0;
	endtask

	// Ages biased toward the current class bounds
	function automatic logic [7:0] pick_age();
		case ($urandom_range(0, 7))
			0: return child_lim;
			1: return child_lim + 8'd1;
			2: return senior_lim - 8'd1;
			3: return senior_lim;
			4: return 8'd0;
			5: return 8'd255;
			default: return 8'($urandom_range(0, 255));
		endcase
	endfunction

	// Reset bounds: empty serve, both classes, strict priority on serve
	task automatic test_reset_state();
		send_item(CMD_SERVE, 8'd0, 32'd0);
		send_item(CMD_REGISTER, 8'd0,   32'h0000_0000);
		send_item(CMD_REGISTER, 8'd13,  32'hFFFF_FFFF);
		send_item(CMD_REGISTER, 8'd12,  32'hAAAA_AAAA);
		send_item(CMD_REGISTER, 8'd59,  32'h5555_5555);
		send_item(CMD_REGISTER, 8'd60,  32'h0000_0001);
		send_item(CMD_REGISTER, 8'd255, 32'h8000_0000);
		repeat (7) send_item(CMD_SERVE, 8'hFF, 32'hFFFF_FFFF);
		wait_drained();
	endtask

	// Extreme and overlapping bounds
	task automatic test_bound_extremes();
		write_reg(CFG_CHILD_AGE_MAX, 8'd0);
		write_reg(CFG_SENIOR_AGE_MIN, 8'd255);
		send_item(CMD_REGISTER, 8'd0,   32'h1234_5678);
		send_item(CMD_REGISTER, 8'd1,   32'h9ABC_DEF0);
		send_item(CMD_REGISTER, 8'd254, 32'h0F0F_0F0F);
		send_item(CMD_REGISTER, 8'd255, 32'hF0F0_F0F0);
		repeat (4) send_item(CMD_SERVE, 8'd0, 32'd0);
		wait_drained();
		// every age meets a bound
		write_reg(CFG_CHILD_AGE_MAX, 8'd255);
		write_reg(CFG_SENIOR_AGE_MIN, 8'd0);
		send_item(CMD_REGISTER, 8'd128, 32'hDEAD_BEEF);
		wait_drained();
		write_reg(CFG_CHILD_AGE_MAX, 8'd200);
		write_reg(CFG_SENIOR_AGE_MIN, 8'd100);
		send_item(CMD_REGISTER, 8'd150, 32'hCAFE_F00D);
		repeat (2) send_item(CMD_SERVE, 8'd0, 32'd0);
		wait_drained();
	endtask

	// Writes to undefined register indexes leave the bounds alone
	task automatic test_unknown_register();
		write_reg(CFG_SENIOR_AGE_MIN + 8'd1, 8'hFF);
		write_reg(8'hFF, 8'h00);
		send_item(CMD_REGISTER, 8'd150, 32'h0BAD_CAFE);
		send_item(CMD_SERVE, 8'd0, 32'd0);
		wait_drained();
	endtask

	// Long receiver hold-off while requests keep coming: input must stall
	task automatic test_backpressure();
		tx_idle  = 1'b0;
		hold_off = 300;
		repeat (48) begin
			send_item($urandom_range(0, 2) == 0 ? CMD_SERVE : CMD_REGISTER, pick_age(),
				$urandom());
		end
		wait_drained();
	endtask

	// Random settings and traffic: fill/drain bursts with some noise
	task automatic test_random_traffic();
		int n;
		while (items_sent < ITEM_TARGET - 2 * TAIL_PAIRS) begin
			case ($urandom_range(0, 5))
				0: begin
					write_reg(CFG_CHILD_AGE_MAX, 8'd0);
					write_reg(CFG_SENIOR_AGE_MIN, 8'd255);
				end
				1: begin
					write_reg(CFG_SENIOR_AGE_MIN, 8'd0);
					write_reg(CFG_CHILD_AGE_MAX, 8'd255);
				end
				2: begin
					write_reg(CFG_CHILD_AGE_MAX, CHILD_AGE_RESET);
					write_reg(CFG_SENIOR_AGE_MIN, SENIOR_AGE_RESET);
				end
				default: begin
					write_reg(CFG_SENIOR_AGE_MIN, 8'($urandom_range(0, 255)));
					write_reg(CFG_CHILD_AGE_MAX, 8'($urandom_range(0, 255)));
				end
			endcase
			tx_idle = ($urandom_range(0, 3) != 0);
			rx_idle = ($urandom_range(0, 3) != 0);
			repeat ($urandom_range(4, 10)) begin
				if (items_sent >= ITEM_TARGET - 2 * TAIL_PAIRS) break;
				if ($urandom_range(0, 9) < 7) begin
					n = $urandom_range(1, 24);
					repeat (n) send_item(CMD_REGISTER, pick_age(), $urandom());
					n = $urandom_range(1, 24);
					repeat (n) send_item(CMD_SERVE, 8'($urandom_range(0, 255)), $urandom());
				end else begin
					n = $urandom_range(1, 16);
					repeat (n) send_item(cmd_t'($urandom_range(0, 1)), pick_age(), $urandom());
				end
			end
			wait_drained();
		end
	endtask

	// Closing stretch of register/serve pairs, no idling on either side
	task automatic test_closing_no_idle();
		tx_idle = 1'b0;
		rx_idle = 1'b0;
		repeat (TAIL_PAIRS) begin
			send_item(CMD_REGISTER, pick_age(), $urandom());
			send_item(CMD_SERVE, 8'd0, 32'd0);
		end
		wait_drained();
	endtask

	// Test sequence
	initial begin
		arst_n        = 1'b0;
		s_axis_tvalid = 1'b0;
		s_axis_tuser  = 1'b0;
		s_axis_tdata  = '0;
		m_axis_tready = 1'b0;
		cfg_valid     = 1'b0;
		cfg_index     = '0;
		cfg_data      = '0;
		tx_idle       = 1'b1;
		rx_idle       = 1'b1;
		hold_off      = 0;
		stall_left    = 0;
		items_sent    = 0;
		fail_count    = 0;
		stall_cycles  = 0;
		repeat (3) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;

		test_reset_state();
		test_bound_extremes();
		test_unknown_register();
		test_backpressure();
		test_random_traffic();
		test_closing_no_idle();

		repeat (10) @(posedge clk);
		$display("%0d requests: %0d registered, %0d rejected full, %0d served, %0d on empty",
			items_sent, status_seen[STAT_REGISTERED], status_seen[STAT_REJECTED],
			status_seen[STAT_SERVED], status_seen[STAT_EMPTY]);
		$display("bounds swept incl. extremes, back-to-back tail, input stalled %0d cycles",
			stall_cycles);
		if (fail_count == 0) begin
			$display("two_class_priority_queue regression: pass");
		end else begin
			$display("two_class_priority_queue regression: fail");
		end
		$finish;
	end

endmodule
